// ===== rtl/core/motor_reply_frame_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Motor reply frame decoder assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MOTOR_REPLY_FRAME_DECODER_TOP_DEFINES_SVH
`define MOTOR_REPLY_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MRFD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrfd implication check failed");
`define MRFD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mrfd forbidden condition seen");
`else
`define MRFD_ASSERT_IMPLY(label, ante, cons)
`define MRFD_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== rtl/core/mrfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor reply frame decoder package
// Shared constants, register indexes and inter-module records.
// ----------------------------------------------------------------------------
package mrfd_pkg;

    localparam logic [7:0] SYNC_FIRST    = 8'h12;
    localparam logic [7:0] SYNC_SECOND   = 8'h34;
    localparam logic [7:0] MAX_FRAME_LEN = 8'd40;
    localparam logic [7:0] MEAS_ID       = 8'd7;

    localparam int         LEN_W         = 6;
    localparam logic [5:0] MEAS_MIN_LEN  = 6'd11;
    localparam int         KEPT_BYTES    = 10;

    localparam logic [13:0] VOLT_SCALE   = 14'd15800;
    localparam logic signed [21:0] CURRENT_SCALE = 22'sd21;

    localparam logic [15:0] CURRENT_ZERO_RST = 16'd2100;

    localparam logic OP_FEED    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [1:0] REG_CURRENT_ZERO = 2'd0;
    localparam logic [1:0] REG_ANGLE_OFFSET = 2'd1;
    localparam logic [1:0] REG_REVERSE      = 2'd2;

    typedef struct packed {
        logic [15:0] current_zero;
        logic [15:0] angle_offset;
        logic        reverse;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  frame_id;
        logic [7:0]  motor_status;
        logic        meas_valid;
        logic [15:0] raw_current;
        logic [15:0] raw_voltage;
        logic [15:0] raw_speed;
        logic [15:0] raw_angle;
    } frame_t;

endpackage

// ===== rtl/core/mrfd_regs.sv =====
// ----------------------------------------------------------------------------
// Motor reply frame decoder configuration registers
// APB-style register file for current zero, angle offset and reverse.
// ----------------------------------------------------------------------------
module mrfd_regs
    import mrfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_zero <= CURRENT_ZERO_RST;
            cfg_reg.angle_offset <= 16'd0;
            cfg_reg.reverse      <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CURRENT_ZERO: cfg_reg.current_zero <= pwdata[15:0];
                REG_ANGLE_OFFSET: cfg_reg.angle_offset <= pwdata[15:0];
                REG_REVERSE:      cfg_reg.reverse      <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CURRENT_ZERO: prdata = {16'd0, cfg_reg.current_zero};
            REG_ANGLE_OFFSET: prdata = {16'd0, cfg_reg.angle_offset};
            REG_REVERSE:      prdata = {31'd0, cfg_reg.reverse};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/mrfd_parser.sv =====
// ----------------------------------------------------------------------------
// Motor reply frame decoder parser
// Sync hunt, length check and payload capture into a frame record register.
// ----------------------------------------------------------------------------
module mrfd_parser
    import mrfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_op,
    input  logic [7:0] in_byte,
    output logic       frame_valid,
    input  logic       frame_ready,
    output frame_t     frame
);

    typedef enum logic [1:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        GET_LEN,
        PAYLOAD
    } hunt_t;

    hunt_t            state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [7:0]       bytes_reg [KEPT_BYTES];
    logic [7:0]       view [KEPT_BYTES];
    logic             fvalid_reg;
    frame_t           frame_reg;
    frame_t           frame_next;

    logic             accept;
    logic             feed;
    logic [LEN_W-1:0] count_inc;
    logic             frame_end;

    assign in_ready    = !fvalid_reg || frame_ready;
    assign accept      = in_valid && in_ready;
    assign feed        = accept && (in_op == OP_FEED);
    assign count_inc   = count_reg + 1'b1;
    assign frame_end   = feed && (state_reg == PAYLOAD) && (count_inc >= len_reg);
    assign frame_valid = fvalid_reg;
    assign frame       = frame_reg;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        count_next = count_reg;
        if (accept && (in_op == OP_RESTART))
        begin
            state_next = HUNT_SYNC1;
        end
        else if (feed)
        begin
            unique case (state_reg)
                HUNT_SYNC1:
                begin
                    if (in_byte == SYNC_FIRST)
                        state_next = HUNT_SYNC2;
                end
                HUNT_SYNC2:
                begin
                    state_next = (in_byte == SYNC_SECOND) ? GET_LEN : HUNT_SYNC1;
                end
                GET_LEN:
                begin
                    if (in_byte > MAX_FRAME_LEN)
                    begin
                        state_next = HUNT_SYNC1;
                    end
                    else
                    begin
                        len_next   = in_byte[LEN_W-1:0];
                        count_next = '0;
                        state_next = PAYLOAD;
                    end
                end
                PAYLOAD:
                begin
                    count_next = count_inc;
                    if (count_inc >= len_reg)
                        state_next = HUNT_SYNC1;
                end
                default: state_next = HUNT_SYNC1;
            endcase
        end
    end

    // merge the byte of this transfer into the stored payload
    always_comb
    begin
        for (int k = 0; k < KEPT_BYTES; k++)
            view[k] = (count_reg == LEN_W'(k)) ? in_byte : bytes_reg[k];
    end

    always_comb
    begin
        frame_next.frame_id     = view[0];
        frame_next.motor_status = (len_reg >= LEN_W'(2)) ? view[1] : 8'd0;
        frame_next.meas_valid   = (view[0] == MEAS_ID) && (len_reg >= MEAS_MIN_LEN);
        frame_next.raw_current  = {view[3], view[2]};
        frame_next.raw_voltage  = {view[5], view[4]};
        frame_next.raw_speed    = {view[7], view[6]};
        frame_next.raw_angle    = {view[9], view[8]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= HUNT_SYNC1;
            len_reg    <= '0;
            count_reg  <= '0;
            fvalid_reg <= 1'b0;
            frame_reg  <= '0;
            for (int k = 0; k < KEPT_BYTES; k++)
                bytes_reg[k] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            if (frame_end)
                fvalid_reg <= 1'b1;
            else if (frame_ready)
                fvalid_reg <= 1'b0;
            if (feed && (state_reg == PAYLOAD))
            begin
                for (int k = 0; k < KEPT_BYTES; k++)
                begin
                    if (count_reg == LEN_W'(k))
                        bytes_reg[k] <= in_byte;
                end
            end
            if (frame_end)
                frame_reg <= frame_next;
        end
    end

endmodule

// ===== rtl/core/mrfd_decode.sv =====
// ----------------------------------------------------------------------------
// Motor reply frame decoder measurement scaling
// Scales the raw measurement words and holds the result register.
// ----------------------------------------------------------------------------
module mrfd_decode
    import mrfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        frame_valid,
    output logic        frame_ready,
    input  frame_t      frame,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [95:0] out_data,
    output logic        out_meas
);

    logic               ovalid_reg;
    logic [95:0]        odata_reg;
    logic               omeas_reg;

    logic [29:0]        volt_prod;
    logic signed [16:0] cur_diff;
    logic signed [21:0] cur_prod;
    logic signed [16:0] spd_raw;
    logic signed [16:0] spd_val;
    logic [15:0]        ang_val;
    logic [95:0]        odata_next;

    assign frame_ready = !ovalid_reg || out_ready;
    assign out_valid   = ovalid_reg;
    assign out_data    = odata_reg;
    assign out_meas    = omeas_reg;

    always_comb
    begin
        volt_prod = {14'd0, frame.raw_voltage} * {16'd0, VOLT_SCALE};
        cur_diff  = $signed({1'b0, frame.raw_current}) - $signed({1'b0, cfg.current_zero});
        cur_prod  = $signed({{5{cur_diff[16]}}, cur_diff}) * CURRENT_SCALE;
        spd_raw   = $signed({frame.raw_speed[15], frame.raw_speed});
        spd_val   = cfg.reverse ? -spd_raw : spd_raw;
        ang_val   = frame.raw_angle - cfg.angle_offset;

        odata_next        = '0;
        odata_next[7:0]   = frame.frame_id;
        odata_next[15:8]  = frame.motor_status;
        if (frame.meas_valid)
        begin
            odata_next[35:16] = volt_prod[29:10];
            odata_next[56:36] = cur_prod[21:1];
            odata_next[73:57] = spd_val;
            odata_next[89:74] = ang_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (frame_ready)
            ovalid_reg <= frame_valid;
    end

    always_ff @(posedge clk)
    begin
        if (frame_ready && frame_valid)
        begin
            odata_reg <= odata_next;
            omeas_reg <= frame.meas_valid;
        end
    end

endmodule

// ===== rtl/core/motor_reply_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Motor reply frame decoder top level
// Byte stream in, one decoded reply record out per completed frame.
// ----------------------------------------------------------------------------
// Takes one link byte per cycle on the slave stream. A completed frame moves
// into a frame record register on the transfer of its last byte and from there
// moves into the result register once the result register is free. The byte
// stream stalls only while the frame record register is full and the result
// register is held by a stalled master side.
`include "motor_reply_frame_decoder_top_defines.svh"

module motor_reply_frame_decoder_top
    import mrfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] frame_id, [15:8] motor_status, [35:16] voltage_mv,
    // [56:36] current_ma, [73:57] speed_rpm, [89:74] angle, [95:90] zero
    output logic [95:0] m_tdata,
    output logic [0:0]  m_tuser,   // [0] meas_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t   cfg;
    frame_t frame;
    logic   frame_valid;
    logic   frame_ready;

    mrfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser[0]),
        .in_byte     (s_tdata),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    mrfd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_meas    (m_tuser[0])
    );

    `MRFD_ASSERT_IMPLY(a_stall_only_when_full, !s_tready, frame_valid && m_tvalid && !m_tready)
    `MRFD_ASSERT_IMPLY(a_no_meas_zero, m_tvalid && !m_tuser[0], m_tdata[89:16] == 74'd0)
    `MRFD_ASSERT_NEVER(a_meas_id, m_tvalid && m_tuser[0] && (m_tdata[7:0] != MEAS_ID))

endmodule
